// ===== design/vhkf_pkg.sv =====
// Shared types and constants for the vertex height fusion block.
package vhkf_pkg;

	// Saturated and minimum measurement variance, Q16.32
	localparam logic [47:0] VAR_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] VAR_FLOOR = 48'd4295;
	localparam logic [31:0] CELL_LENGTH_RESET = 32'd65536;

	// Step counts of the shared unit
	localparam logic [5:0] SQRT_STEPS  = 6'd24;
	localparam logic [5:0] RATIO_STEPS = 6'd40;
	localparam logic [5:0] SCALE_STEPS = 6'd41;
	localparam logic [5:0] GAIN_STEPS  = 6'd33;

	typedef enum logic [1:0] {
		OP_SQRT,
		OP_DIV,
		OP_MUL
	} unit_op_t;

	// Request to the shared shift/add/subtract unit
	typedef struct packed {
		logic        start;
		unit_op_t    op;
		logic [63:0] opa;   // sqrt radicand, dividend or multiplier, MSB aligned
		logic [31:0] opb;   // divisor or multiplicand
		logic [31:0] rem0;  // starting partial remainder
		logic [5:0]  steps;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [72:0] result;
	} unit_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_SQRT,
		ST_RATIO,
		ST_SCALE,
		ST_SQUARE,
		ST_MVAR,
		ST_SUM,
		ST_NORM,
		ST_GAIN,
		ST_FUSE_H,
		ST_FUSE_LO,
		ST_FUSE_HI,
		ST_WRITE
	} state_t;

endpackage

// ===== design/vhkf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module vhkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/vhkf_unit.sv =====
// Shared iterative unit: square root, restoring division and shift-add multiply.
module vhkf_unit
	import vhkf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	unit_op_t    op_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [72:0] ra_q;  // sqrt remainder / division remainder / product
	logic [63:0] rb_q;  // sqrt root / dividend / multiplier
	logic [47:0] rc_q;  // sqrt bit / quotient
	logic [31:0] rd_q;  // divisor / multiplicand

	logic [72:0] ra_d;
	logic [63:0] rb_d;
	logic [47:0] rc_d;
	logic [48:0] sq_sum;
	logic        sq_ge;
	logic [32:0] dv_t;
	logic [32:0] dv_sub;
	logic        dv_ge;

	// one step of the selected operation
	always_comb begin
		sq_sum = {1'b0, rb_q[47:0]} + {1'b0, rc_q};
		sq_ge  = {1'b0, ra_q[47:0]} >= sq_sum;
		dv_t   = {ra_q[31:0], rb_q[63]};
		dv_sub = dv_t - {1'b0, rd_q};
		dv_ge  = dv_t >= {1'b0, rd_q};
		ra_d   = ra_q;
		rb_d   = rb_q;
		rc_d   = rc_q;
		unique case (op_q)
			OP_SQRT: begin
				ra_d = sq_ge ? {25'b0, ra_q[47:0] - sq_sum[47:0]} : ra_q;
				rb_d = sq_ge ? {16'b0, (rb_q[47:0] >> 1) + rc_q} : {17'b0, rb_q[47:1]};
				rc_d = rc_q >> 2;
			end
			OP_DIV: begin
				ra_d = {41'b0, dv_ge ? dv_sub[31:0] : dv_t[31:0]};
				rb_d = {rb_q[62:0], 1'b0};
				rc_d = {rc_q[46:0], dv_ge};
			end
			OP_MUL: begin
				ra_d = {ra_q[71:0], 1'b0} + (rb_q[63] ? {41'b0, rd_q} : 73'b0);
				rb_d = {rb_q[62:0], 1'b0};
			end
			default: begin
				ra_d = ra_q;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_SQRT;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q   <= req.op;
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			unique case (req.op)
				OP_SQRT: begin
					ra_q <= {9'b0, req.opa};
					rb_q <= '0;
					rc_q <= 48'h4000_0000_0000;
				end
				OP_DIV: begin
					ra_q <= {41'b0, req.rem0};
					rb_q <= req.opa;
					rc_q <= '0;
				end
				OP_MUL: begin
					ra_q <= '0;
					rb_q <= req.opa;
					rc_q <= '0;
				end
				default: begin
					ra_q <= '0;
				end
			endcase
			rd_q <= req.opb;
		end else if (busy_q) begin
			ra_q <= ra_d;
			rb_q <= rb_d;
			rc_q <= rc_d;
		end
	end

	always_comb begin
		rsp.done = done_q;
		unique case (op_q)
			OP_SQRT: rsp.result = {25'b0, rb_q[47:0]};
			OP_DIV:  rsp.result = {25'b0, rc_q};
			OP_MUL:  rsp.result = ra_q;
			default: rsp.result = '0;
		endcase
	end

endmodule

// ===== design/vertex_height_kalman_fusion.sv =====
// Vertex height fusion: sequencer, stores and shared multiplier.
//
// Usage: each word on s_* carries one height measurement for a mesh vertex.
// The block inflates its variance with the distance to the vertex, then
// either stores it (vertex not yet seen) or runs a one-dimensional Kalman
// update of the stored height and variance. Every input word gives exactly
// one word on m_*: the vertex index with its height and variance after the
// update (zeros for an index of VERTEX_COUNT or above, store left unchanged).
// cfg_* writes the cell edge length; the user must write it only while idle,
// as the block itself does not enforce it. The time from acceptance to result
// is set by the bit-serial unit: 24 square-root steps, 40 divide steps, 41
// multiply steps, and for a fused update up to 17 normalize shifts and 33 gain
// divide steps.
// One word is worked on at a time; s_tready is high only between words.
// Reset clears the valid store with a sweep over all VERTEX_COUNT addresses,
// during which no word is accepted; cell length returns to 1.0.
// A stalled receiver holds the result in the output register; the next word
// is accepted meanwhile and waits at its end until the register is free.
module vertex_height_kalman_fusion
	import vhkf_pkg::*;
#(
	parameter int VERTEX_COUNT = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vertex_index[11:0], measured_height[43:12], measured_deviation[75:44],
	// squared_distance[107:76], zero fill
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// updated_vertex[11:0], fused_height[43:12], fused_variance[91:44], zero fill
	output logic [95:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_COUNT - 1);
	localparam logic [31:0] VCOUNT = 32'(VERTEX_COUNT);

	state_t state_q, state_d;
	unit_req_t req;
	unit_rsp_t rsp;

	logic [31:0]        cell_length_q;
	logic [AW-1:0]      clr_q;
	logic [11:0]        idx_q;
	logic [31:0]        m_q;
	logic [31:0]        s_q;
	logic [31:0]        d2_q;
	logic               inrng_q;
	logic               fuse_q;
	logic               sat_q;
	logic [47:0]        var_q;
	logic [47:0]        num_q;
	logic [48:0]        den_q;
	logic               neg_q;
	logic [32:0]        mag_q;
	logic [32:0]        k_q;
	logic [65:0]        prod_q;
	logic [32:0]        lo_q;
	logic [31:0]        hnew_q;
	logic               m_tvalid_q;
	logic [11:0]        out_idx_q;
	logic [31:0]        out_h_q;
	logic [47:0]        out_v_q;

	logic               accept;
	logic               fire;
	logic [32:0]        mul_a, mul_b;
	logic [65:0]        prod;
	logic [40:0]        factor;
	logic [31:0]        divisor;
	logic [AW+11:0]     in_ext, idx_ext;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic               vld_we, vld_wdata, vld_rdata;
	logic [79:0]        hv_rdata;
	logic [31:0]        h_old;
	logic [47:0]        v_old;
	logic [32:0]        diff;
	logic [31:0]        res_h;
	logic [47:0]        res_v;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign fire      = (state_q == ST_WRITE) && (!m_tvalid_q || m_tready);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {4'b0, out_v_q, out_h_q, out_idx_q};

	// vertex addressing
	assign in_ext  = {{AW{1'b0}}, s_tdata[11:0]};
	assign idx_ext = {{AW{1'b0}}, idx_q};
	assign rd_addr = in_ext[AW-1:0];
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : idx_ext[AW-1:0];
	assign h_old   = hv_rdata[31:0];
	assign v_old   = hv_rdata[79:32];
	assign vld_we    = (state_q == ST_CLEAR) || (fire && inrng_q);
	assign vld_wdata = (state_q != ST_CLEAR);

	vhkf_ram #(.WIDTH(80), .DEPTH(VERTEX_COUNT)) u_hv_ram (
		.clk   (clk),
		.we    (fire && inrng_q),
		.waddr (wr_addr),
		.wdata ({res_v, res_h}),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (hv_rdata)
	);

	vhkf_ram #(.WIDTH(1), .DEPTH(VERTEX_COUNT)) u_vld_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (wr_addr),
		.wdata (vld_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (vld_rdata)
	);

	vhkf_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shared multiplier
	always_comb begin
		unique case (state_q)
			ST_SQUARE: begin
				mul_a = {9'b0, rsp.result[39:16]};
				mul_b = {9'b0, rsp.result[39:16]};
			end
			ST_FUSE_H: begin
				mul_a = mag_q;
				mul_b = k_q;
			end
			ST_FUSE_LO: begin
				mul_a = {1'b0, var_q[31:0]};
				mul_b = k_q;
			end
			default: begin
				mul_a = {17'b0, var_q[47:32]};
				mul_b = k_q;
			end
		endcase
		prod = mul_a * mul_b;
	end

	assign factor  = 41'd65536 + {1'b0, rsp.result[39:0]};
	assign divisor = (cell_length_q == 32'd0) ? 32'd1 : cell_length_q;
	assign diff    = {m_q[31], m_q} - {h_old[31], h_old};

	// result selection for the write-back
	always_comb begin
		if (!inrng_q) begin
			res_h = '0;
			res_v = '0;
		end else if (!fuse_q) begin
			res_h = m_q;
			res_v = var_q;
		end else begin
			res_h = hnew_q;
			res_v = prod_q[47:0] + {15'b0, lo_q};
		end
	end

	// sequencer: next state and unit requests
	always_comb begin
		state_d   = state_q;
		req.op    = OP_SQRT;
		req.opa   = '0;
		req.opb   = '0;
		req.rem0  = '0;
		req.steps = SQRT_STEPS;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			ST_IDLE:    if (accept) state_d = ST_LOAD;
			ST_LOAD: begin
				state_d = ST_SQRT;
				req.op  = OP_SQRT;
				req.opa = {16'b0, d2_q, 16'b0};
			end
			ST_SQRT: begin
				if (rsp.done) state_d = ST_RATIO;
				req.op    = OP_DIV;
				req.opa   = {rsp.result[23:0], 40'b0};
				req.opb   = divisor;
				req.steps = RATIO_STEPS;
			end
			ST_RATIO: begin
				if (rsp.done) state_d = ST_SCALE;
				req.op    = OP_MUL;
				req.opa   = {factor, 23'b0};
				req.opb   = s_q;
				req.steps = SCALE_STEPS;
			end
			ST_SCALE:   if (rsp.done) state_d = ST_SQUARE;
			ST_SQUARE:  state_d = ST_MVAR;
			ST_MVAR:    state_d = (inrng_q && vld_rdata) ? ST_SUM : ST_WRITE;
			ST_SUM:     state_d = ST_NORM;
			ST_NORM: begin
				if (den_q[48:32] == 17'd0) state_d = ST_GAIN;
				req.op    = OP_DIV;
				req.opa   = {num_q[0], 63'b0};
				req.opb   = den_q[31:0];
				req.rem0  = num_q[32:1];
				req.steps = GAIN_STEPS;
			end
			ST_GAIN:    if (rsp.done) state_d = ST_FUSE_H;
			ST_FUSE_H:  state_d = ST_FUSE_LO;
			ST_FUSE_LO: state_d = ST_FUSE_HI;
			ST_FUSE_HI: state_d = ST_WRITE;
			ST_WRITE:   if (fire) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
		req.start = (state_d != state_q) && ((state_d == ST_SQRT) || (state_d == ST_RATIO) ||
			(state_d == ST_SCALE) || (state_d == ST_GAIN));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			cell_length_q <= CELL_LENGTH_RESET;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				cell_length_q <= cfg_data;
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= s_tdata[11:0];
			m_q     <= s_tdata[43:12];
			s_q     <= s_tdata[75:44];
			d2_q    <= s_tdata[107:76];
			inrng_q <= {20'b0, s_tdata[11:0]} < VCOUNT;
		end
		unique case (state_q)
			ST_SQUARE: begin
				prod_q <= prod;
				sat_q  <= |rsp.result[72:40];
			end
			ST_MVAR: begin
				fuse_q <= inrng_q && vld_rdata;
				if (sat_q) begin
					var_q <= VAR_MAX;
				end else if (prod_q[47:0] == 48'd0) begin
					var_q <= VAR_FLOOR;
				end else begin
					var_q <= prod_q[47:0];
				end
			end
			ST_SUM: begin
				num_q <= v_old;
				den_q <= {1'b0, v_old} + {1'b0, var_q};
				neg_q <= diff[32];
				mag_q <= diff[32] ? (33'd0 - diff) : diff;
			end
			ST_NORM: begin
				if (den_q[48:32] != 17'd0) begin
					num_q <= num_q >> 1;
					den_q <= den_q >> 1;
				end
			end
			ST_GAIN: begin
				if (rsp.done) k_q <= rsp.result[32:0];
			end
			ST_FUSE_H: begin
				prod_q <= prod;
			end
			ST_FUSE_LO: begin
				hnew_q <= neg_q ? (h_old - prod_q[63:32]) : (h_old + prod_q[63:32]);
				prod_q <= prod;
			end
			ST_FUSE_HI: begin
				lo_q   <= prod_q[64:32];
				prod_q <= prod;
			end
			default: begin
			end
		endcase
		if (fire) begin
			out_idx_q <= idx_q;
			out_h_q   <= res_h;
			out_v_q   <= res_v;
		end
	end

	// the unit only reports completion while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_SQRT || state_q == ST_RATIO ||
			state_q == ST_SCALE || state_q == ST_GAIN))
		else $error("unit done outside a wait state");

	// an accepted word moves straight to operand load
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOAD)
		else $error("accepted word not loaded");

	// gain divide runs on a normalized denominator
	a_norm_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GAIN |-> den_q[48:32] == 17'd0)
		else $error("gain divisor not normalized");

	// Kalman gain never exceeds one
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FUSE_H |-> k_q <= 33'h1_0000_0000)
		else $error("gain above one");

endmodule

// ===== bench/vhkf_checker.sv =====
// Checker for the vertex height fusion block: predicts each result and compares it.
`timescale 1ns / 100ps

module vhkf_checker
	import vhkf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	output int           pending,
	output int           errors
);

	typedef struct {
		logic [11:0] vertex;
		logic [31:0] height;
		logic [47:0] variance;
	} fused_word_t;

	// expected words in arrival order
	fused_word_t exp_fifo [64];
	int          wr_ptr = 0;
	int          rd_ptr = 0;

	logic [31:0] cell_len;
	logic [31:0] height_mem [4096];
	logic [47:0] var_mem [4096];
	logic        seen [4096];

	assign pending = wr_ptr - rd_ptr;

	// Inflated measurement variance, Q16.32
	function automatic logic [47:0] meas_var(logic [31:0] dev, logic [31:0] d2,
			logic [31:0] len);
		logic [63:0] x, r, bit_v, ratio, factor, a;
		logic [95:0] prod;
		x = {16'd0, d2, 16'd0};
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (x >= r + bit_v) begin
				x = x - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		ratio = (r << 16) / ((len == 0) ? 64'd1 : {32'd0, len});
		factor = 64'd65536 + ratio;
		prod = {64'd0, dev} * {32'd0, factor};
		if (prod[95:64] != 0) return VAR_MAX;
		a = prod[63:16];
		if (a >= (64'd1 << 24)) return VAR_MAX;
		a = a * a;
		return (a == 0) ? VAR_FLOOR : a[47:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [11:0]  idx;
		logic [31:0]  mh;
		logic [47:0]  mv;
		logic signed [63:0] h, diff;
		logic [63:0]  num, den, k, mag, delta, nv;
		fused_word_t  exp_w, got_w;
		if (!arst_n) begin
			cell_len <= CELL_LENGTH_RESET;
			for (int i = 0; i < 4096; i++) seen[i] = 1'b0;
			wr_ptr = 0;
			rd_ptr = 0;
			errors <= 0;
		end else begin
			// config write; the bench sends it only while idle
			if (cfg_valid && cfg_ready) cell_len <= cfg_data;

			// accepted measurement: update the predicted store
			if (s_tvalid && s_tready) begin
				idx = s_tdata[11:0];
				mh  = s_tdata[43:12];
				mv  = meas_var(s_tdata[75:44], s_tdata[107:76], cell_len);
				if (!seen[idx]) begin
					height_mem[idx] = mh;
					var_mem[idx] = mv;
					seen[idx] = 1'b1;
				end else begin
					h = $signed(height_mem[idx]);
					num = {16'd0, var_mem[idx]};
					den = num + {16'd0, mv};
					while (den >= (64'd1 << 32)) begin
						num = num >> 1;
						den = den >> 1;
					end
					k = (num << 32) / den;
					diff = $signed({{32{mh[31]}}, mh}) - h;
					mag = (diff < 0) ? -diff : diff;
					delta = (mag * k) >> 32;
					h = (diff < 0) ? h - $signed(delta) : h + $signed(delta);
					nv = ({48'd0, mv[47:32]} * k) + (({32'd0, mv[31:0]} * k) >> 32);
					height_mem[idx] = h[31:0];
					var_mem[idx] = nv[47:0];
				end
				exp_w.vertex = idx;
				exp_w.height = height_mem[idx];
				exp_w.variance = var_mem[idx];
				exp_fifo[wr_ptr % 64] = exp_w;
				wr_ptr++;
			end

			// result word: compare with oldest prediction
			if (m_tvalid && m_tready) begin
				got_w.vertex = m_tdata[11:0];
				got_w.height = m_tdata[43:12];
				got_w.variance = m_tdata[91:44];
				if (wr_ptr == rd_ptr) begin
					if (errors < 10)
						$display("unexpected result word: vtx %0d h %h v %h",
							got_w.vertex, got_w.height, got_w.variance);
					errors <= errors + 1;
				end else begin
					exp_w = exp_fifo[rd_ptr % 64];
					rd_ptr++;
					if (got_w.vertex !== exp_w.vertex || got_w.height !== exp_w.height ||
							got_w.variance !== exp_w.variance) begin
						if (errors < 10)
							$display("mismatch: exp vtx %0d h %h v %h, got vtx %0d h %h v %h",
								exp_w.vertex, exp_w.height, exp_w.variance,
								got_w.vertex, got_w.height, got_w.variance);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== bench/tb_vertex_height_kalman_fusion.sv =====
// Testbench top for the vertex height fusion block: stimulus and verdict.
`timescale 1ns / 100ps

module tb_vertex_height_kalman_fusion
	import vhkf_pkg::*;
();

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// vertex_index, measured_height, measured_deviation, squared_distance, zero fill
	logic [111:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// updated_vertex, fused_height, fused_variance, zero fill
	logic [95:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;
	int           pending;
	int           errors;
	int           cycles;
	int           burst_left;
	int           stall_mode, stall_left;
	logic [11:0]  hot_vtx [24];

	vertex_height_kalman_fusion #(.VERTEX_COUNT(4096)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	vhkf_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver stalls: stretches of always ready, random, and mostly stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(64, 400);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 800000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// drop the sender and wait until every expected word has come
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_cell_length(logic [31:0] len);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one measurement word, sent in bursts with random gaps
	task automatic send_meas(logic [11:0] vtx, logic [31:0] h, logic [31:0] dev,
			logic [31:0] d2);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, d2, dev, h, vtx};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		burst_left--;
	endtask

	task automatic send_random();
		logic [11:0] vtx;
		logic [31:0] h, dev, d2;
		vtx = ($urandom_range(0, 9) < 8) ? hot_vtx[$urandom_range(0, 23)] : 12'($urandom);
		case ($urandom_range(0, 3))
			0: h = $urandom;
			default: h = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
		endcase
		case ($urandom_range(0, 7))
			0: dev = $urandom;
			1: dev = 0;
			2: dev = $urandom_range(0, 3);
			default: dev = $urandom_range(1, 32'h0004_0000);
		endcase
		case ($urandom_range(0, 5))
			0: d2 = $urandom;
			1: d2 = 0;
			default: d2 = $urandom_range(0, 32'h0010_0000);
		endcase
		send_meas(vtx, h, dev, d2);
	endtask

	initial begin
		logic [31:0] cell_vals [6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		burst_left = 0;
		for (int i = 0; i < 24; i++) hot_vtx[i] = 12'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, zero variance, saturation, first and fused updates
		send_meas(12'd0, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
		send_meas(12'd0, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
		send_meas(12'd4095, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_meas(12'd4095, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
		send_meas(12'd4095, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_meas(12'd1, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_meas(12'd1, 32'h7FFF_FFFF, 32'h0100_0000, 32'h0000_0000);
		send_meas(12'd2, 32'hFFFF_0000, 32'h00FF_FFFF, 32'h0000_0000);
		send_meas(12'd2, 32'h0001_0000, 32'h0000_0001, 32'h0000_0001);
		send_meas(12'd2, 32'hFFFF_FFFF, 32'h0000_0010, 32'h0004_0000);
		send_meas(12'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_meas(12'd0, 32'h0010_0000, 32'h0001_0000, 32'h0000_0000);

		// zero cell length is the smallest step; then the widest
		write_cell_length(32'd0);
		send_meas(12'd3, 32'h0000_1000, 32'h0000_0100, 32'h0000_0001);
		send_meas(12'd3, 32'h0000_2000, 32'h0000_0100, 32'h0000_0000);
		write_cell_length(32'hFFFF_FFFF);
		send_meas(12'd4, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_meas(12'd4, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF);

		// random phases over several cell lengths
		cell_vals[0] = CELL_LENGTH_RESET;
		cell_vals[1] = 32'd1;
		cell_vals[2] = 32'hFFFF_FFFF;
		cell_vals[3] = $urandom;
		cell_vals[4] = 32'd0;
		cell_vals[5] = $urandom_range(32'h0000_4000, 32'h0004_0000);
		for (int p = 0; p < 6; p++) begin
			write_cell_length(cell_vals[p]);
			for (int n = 0; n < 90; n++) send_random();
		end
		s_tvalid <= 1'b0;

		wait_idle();
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
